>>> sv/ffha_pkg.sv
package ffha_pkg;

  // Fixed field widths
  localparam int unsigned SIZE_W         = 17;  // payload size / break offset
  localparam int unsigned OFF_W          = 19;  // walk offset, room for p + 8 + size
  localparam int unsigned HDR_W          = SIZE_W + 1;
  localparam int unsigned DEF_HEAP_WORDS = 16384;

  localparam logic [OFF_W-1:0] HDR_BYTES  = OFF_W'(8);
  localparam logic [31:0]      MAX_REQ    = 32'hFFFF_FFFC;
  localparam logic [32:0]      SPLIT_MIN  = 33'd12;  // header plus smallest remainder
  localparam logic [SIZE_W-1:0] LIMIT_RST = SIZE_W'(65536);

  // Configuration register indexes
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {RD_NONE, RD_P, RD_NP} rd_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_SPLIT, WR_TAKE_H, WR_TAKE_SZ, WR_APPEND, WR_FREE, WR_MERGE
  } wr_op_t;

  typedef enum logic [1:0] {P_KEEP, P_ZERO, P_NP, P_NPQ} p_op_t;

  typedef enum logic [2:0] {RES_NONE, RES_P, RES_BRK, RES_FAIL, RES_ZERO} res_op_t;

  typedef struct packed {
    logic    load;
    rd_op_t  rd;
    wr_op_t  wr;
    p_op_t   pop;
    res_op_t res;
    logic    brk_upd;
  } cmd_t;

  typedef struct packed {
    logic bad_req;   // zero size or rounding overflow
    logic p_in;      // header at p lies below the break
    logic fit;       // header read is free and large enough
    logic split;     // remainder holds a header plus a word
    logic np_in;     // following header lies below the break
    logic rfree;     // header read is free
    logic hit;       // p is the released block
    logic addr_zero; // release of address 0
    logic app_ok;    // appended block stays within the limit
    logic [SIZE_W-1:0] brk;
  } sts_t;

endpackage

>>> sv/ffha_if.sv
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] request_size;
  logic [31:0] block_addr;
  modport source (output valid, func, request_size, block_addr, input ready);
  modport sink   (input valid, func, request_size, block_addr, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_addr;
  logic        failed;
  modport source (output valid, result_addr, failed, input ready);
  modport sink   (input valid, result_addr, failed, output ready);
endinterface

>>> sv/ffha_ctrl.sv
module ffha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ffha_pkg::sts_t sts,
  output ffha_pkg::cmd_t cmd
);
  import ffha_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_AWALK = 11'b000_0000_0010,
    S_AEV   = 11'b000_0000_0100,
    S_ATAKE = 11'b000_0000_1000,
    S_AAPP  = 11'b000_0001_0000,
    S_RFIND = 11'b000_0010_0000,
    S_REV   = 11'b000_0100_0000,
    S_MRD   = 11'b000_1000_0000,
    S_MEV   = 11'b001_0000_0000,
    S_MNEV  = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of the walks
  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.rd      = RD_NONE;
    cmd.wr      = WR_NONE;
    cmd.pop     = P_KEEP;
    cmd.res     = RES_NONE;
    cmd.brk_upd = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = in_func ? S_RFIND : S_AWALK;
        end
      end
      S_AWALK: begin
        if (sts.bad_req) begin
          cmd.res    = RES_FAIL;
          state_next = S_OUT;
        end else if (sts.p_in) begin
          cmd.rd     = RD_P;
          state_next = S_AEV;
        end else begin
          state_next = S_AAPP;
        end
      end
      S_AEV: begin
        if (sts.fit) begin
          if (sts.split) begin
            cmd.wr     = WR_SPLIT;
            state_next = S_ATAKE;
          end else begin
            cmd.wr     = WR_TAKE_H;
            cmd.res    = RES_P;
            state_next = S_OUT;
          end
        end else begin
          cmd.pop    = P_NP;
          state_next = S_AWALK;
        end
      end
      S_ATAKE: begin
        cmd.wr     = WR_TAKE_SZ;
        cmd.res    = RES_P;
        state_next = S_OUT;
      end
      S_AAPP: begin
        if (sts.app_ok) begin
          cmd.wr      = WR_APPEND;
          cmd.res     = RES_BRK;
          cmd.brk_upd = 1'b1;
        end else begin
          cmd.res = RES_FAIL;
        end
        state_next = S_OUT;
      end
      S_RFIND: begin
        if (sts.addr_zero) begin
          cmd.res    = RES_ZERO;
          state_next = S_OUT;
        end else if (sts.p_in) begin
          cmd.rd     = RD_P;
          state_next = S_REV;
        end else begin
          cmd.pop    = P_ZERO;
          state_next = S_MRD;
        end
      end
      S_REV: begin
        if (sts.hit) begin
          cmd.wr     = WR_FREE;
          cmd.pop    = P_ZERO;
          state_next = S_MRD;
        end else begin
          cmd.pop    = P_NP;
          state_next = S_RFIND;
        end
      end
      S_MRD: begin
        if (sts.p_in) begin
          cmd.rd     = RD_P;
          state_next = S_MEV;
        end else begin
          cmd.res    = RES_ZERO;
          state_next = S_OUT;
        end
      end
      S_MEV: begin
        if (sts.rfree && sts.np_in) begin
          cmd.rd     = RD_NP;
          state_next = S_MNEV;
        end else begin
          cmd.pop    = P_NP;
          state_next = S_MRD;
        end
      end
      S_MNEV: begin
        // a merged header is read again in case the next block is free too
        if (sts.rfree) begin
          cmd.wr = WR_MERGE;
        end else begin
          cmd.pop = P_NPQ;
        end
        state_next = S_MRD;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/ffha_dpath.sv
module ffha_dpath #(
  parameter int unsigned HEAP_WORDS = ffha_pkg::DEF_HEAP_WORDS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [31:0]                  cfg_wdata,
  input  logic [31:0]                  in_request_size,
  input  logic [31:0]                  in_block_addr,
  input  ffha_pkg::cmd_t               cmd,
  output ffha_pkg::sts_t               sts,
  output logic [31:0]                  result_addr,
  output logic                         failed
);
  import ffha_pkg::*;

  localparam int unsigned AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam logic [31:0] CAP = 32'(HEAP_WORDS) * 32'd4;

  logic [HDR_W-1:0]  mem [HEAP_WORDS];
  logic [HDR_W-1:0]  rdata;

  logic [31:0]       heap_base;
  logic [SIZE_W-1:0] heap_limit;
  logic [SIZE_W-1:0] brk;
  logic [OFF_W-1:0]  p, np_q;
  logic [31:0]       req_q, size_q, blk_q;
  logic [SIZE_W-1:0] hs_q;

  logic [SIZE_W-1:0] hs;
  logic              used;
  logic [OFF_W-1:0]  np;
  logic [31:0]       lim;
  logic [32:0]       app_end;
  logic [31:0]       target;
  logic              rd_en, wr_en;
  logic [OFF_W-1:0]  rd_off, wr_off;
  logic [HDR_W-1:0]  wr_data;

  function automatic logic [AW-1:0] word_idx(input logic [OFF_W-1:0] off);
    logic [31:0] o32;
    o32 = 32'(off);
    return o32[AW+1:2];
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_HEAP_BASE) begin
        heap_base <= cfg_wdata;
      end else begin
        heap_limit <= cfg_wdata[SIZE_W-1:0];
      end
    end
  end

  // Header fields of the word read
  assign hs      = rdata[SIZE_W-1:0];
  assign used    = rdata[SIZE_W];
  assign np      = p + HDR_BYTES + OFF_W'(hs);
  assign lim     = (32'(heap_limit) < CAP) ? 32'(heap_limit) : CAP;
  assign app_end = 33'(brk) + 33'd8 + 33'(size_q);
  assign target  = blk_q - heap_base - 32'd8;

  assign sts.bad_req   = (req_q == 32'd0) || (req_q > MAX_REQ);
  assign sts.p_in      = (p + HDR_BYTES) <= OFF_W'(brk);
  assign sts.fit       = !used && (32'(hs) >= size_q);
  assign sts.split     = 33'(hs) >= (33'(size_q) + SPLIT_MIN);
  assign sts.np_in     = (20'(np) + 20'd8) <= 20'(brk);
  assign sts.rfree     = !used;
  assign sts.hit       = 32'(p) == target;
  assign sts.addr_zero = (blk_q == 32'd0);
  assign sts.app_ok    = app_end <= 33'(lim);
  assign sts.brk       = brk;

  // Header store port selection
  always_comb begin
    rd_en   = (cmd.rd != RD_NONE);
    rd_off  = (cmd.rd == RD_NP) ? np : p;
    wr_en   = 1'b1;
    wr_off  = p;
    wr_data = '0;
    case (cmd.wr)
      WR_SPLIT: begin
        wr_off  = p + HDR_BYTES + OFF_W'(size_q);
        wr_data = {1'b0, SIZE_W'(hs - SIZE_W'(size_q) - SIZE_W'(8))};
      end
      WR_TAKE_H:  wr_data = {1'b1, hs};
      WR_TAKE_SZ: wr_data = {1'b1, size_q[SIZE_W-1:0]};
      WR_APPEND: begin
        wr_off  = OFF_W'(brk);
        wr_data = {1'b1, size_q[SIZE_W-1:0]};
      end
      WR_FREE:  wr_data = {1'b0, hs};
      WR_MERGE: wr_data = {1'b0, SIZE_W'(hs_q + SIZE_W'(8) + hs)};
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[word_idx(wr_off)] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[word_idx(rd_off)];
    end
  end

  // Break offset
  always_ff @(posedge clk) begin
    if (rst) begin
      brk <= '0;
    end else if (cmd.brk_upd) begin
      brk <= app_end[SIZE_W-1:0];
    end
  end

  // Walk registers and captured request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= in_request_size;
      size_q <= (in_request_size + 32'd3) & ~32'd3;
      blk_q  <= in_block_addr;
    end
    if (cmd.rd == RD_NP) begin
      np_q <= np;
      hs_q <= hs;
    end
    case (cmd.pop)
      P_ZERO:  p <= '0;
      P_NP:    p <= np;
      P_NPQ:   p <= np_q;
      default: if (cmd.load) p <= '0;
    endcase
  end

  // Result word
  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_P: begin
        result_addr <= heap_base + 32'(p) + 32'd8;
        failed      <= 1'b0;
      end
      RES_BRK: begin
        result_addr <= heap_base + 32'(brk) + 32'd8;
        failed      <= 1'b0;
      end
      RES_FAIL: begin
        result_addr <= '0;
        failed      <= 1'b1;
      end
      RES_ZERO: begin
        result_addr <= '0;
        failed      <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/first_fit_heap_allocator.sv
// Channel  Dir  Word fields
// req      in   func, request_size, block_addr
// rsp      out  result_addr, failed
// cfg      in   cfg_we, cfg_index, cfg_wdata (heap_base, heap_limit)
//
// One request at a time, one header access per cycle.
// allocate: first-fit walk, split if room is left, else append at the break; a bad size fails.
// release: walk to the target (through all blocks if absent) and free it, then a merge walk
//   from the start that reads the successor of each free block and merges free pairs.
// Reset clears the break; header store contents are not cleared.
// The result word holds until taken; no new request is taken meanwhile.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_WORDS = ffha_pkg::DEF_HEAP_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  ffha_req_if.sink    req,
  ffha_rsp_if.source  rsp
);
  import ffha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_func   (req.func),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffha_dpath #(.HEAP_WORDS(HEAP_WORDS)) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_request_size (req.request_size),
    .in_block_addr   (req.block_addr),
    .cmd             (cmd),
    .sts             (sts),
    .result_addr     (rsp.result_addr),
    .failed          (rsp.failed)
  );

  // A failed allocate never returns an address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.failed |-> rsp.result_addr == 32'd0)
    else $error("failed result carries an address");

  // No new word is taken while one is in work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  // The break only moves when an allocate succeeds
  a_brk: assert property (@(posedge clk) disable iff (rst)
    sts.brk != $past(sts.brk) |-> $past(cmd.brk_upd))
    else $error("break moved without an append");

  // Break never passes the limit checked at append
  a_brk_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.brk_upd |-> sts.app_ok)
    else $error("append beyond limit");

endmodule

>>> sim/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int unsigned WORDS      = DEF_HEAP_WORDS;
  localparam int unsigned CYCLE_CAP  = 20000000;
  localparam logic        FN_ALLOC   = 1'b0;
  localparam logic        FN_RELEASE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] request_size;
    logic [31:0] block_addr;
  } heap_op_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic        failed;
  } heap_res_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  // Clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Shadow heap state
  logic [31:0]     shadow_base;
  logic [16:0]     shadow_limit;
  logic [17:0]     shadow_hdr [WORDS];
  logic [16:0]     shadow_brk;
  logic [31:0]     live_addrs [$];

  heap_op_t        op_queue [$];
  heap_res_t       expected_results [$];
  int unsigned     err_count;
  int unsigned     cycle_count;
  int unsigned     words_sent;
  int unsigned     words_checked;
  int unsigned     alloc_fails;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     hold_cycles;

  function automatic logic [16:0] limit_in_force();
    if (32'(shadow_limit) < WORDS * 4) return shadow_limit;
    return 17'(WORDS * 4);
  endfunction

  function automatic void set_hdr(logic [31:0] off, logic [31:0] sz, logic used);
    if ((off >> 2) < WORDS) shadow_hdr[off >> 2] = {used, sz[16:0]};
  endfunction

  function automatic logic [17:0] get_hdr(logic [31:0] off);
    if ((off >> 2) < WORDS) return shadow_hdr[off >> 2];
    return '0;
  endfunction

  function automatic heap_res_t predict_alloc(logic [31:0] reqsz);
    heap_res_t   r;
    logic [31:0] sz;
    logic [31:0] p;
    logic [31:0] hs;
    logic [17:0] h;
    logic [63:0] fin;
    r.result_addr = '0;
    r.failed      = 1'b1;
    p = 0;
    if (reqsz == 0 || reqsz > MAX_REQ) return r;
    sz = (reqsz + 3) & ~32'd3;
    while (64'(p) + 8 <= 64'(shadow_brk)) begin
      h  = get_hdr(p);
      hs = 32'(h[16:0]);
      if (!h[17] && hs >= sz) begin
        if (64'(hs) >= 64'(sz) + 12) begin
          set_hdr(p + 8 + sz, hs - sz - 8, 1'b0);
          hs = sz;
        end
        set_hdr(p, hs, 1'b1);
        r.result_addr = shadow_base + p + 8;
        r.failed      = 1'b0;
        return r;
      end
      p = p + 8 + hs;
    end
    fin = 64'(shadow_brk) + 8 + 64'(sz);
    if (fin > 64'(limit_in_force())) return r;
    set_hdr(32'(shadow_brk), sz, 1'b1);
    r.result_addr = shadow_base + 32'(shadow_brk) + 8;
    r.failed      = 1'b0;
    shadow_brk    = fin[16:0];
    return r;
  endfunction

  function automatic void predict_release(logic [31:0] addr);
    logic [31:0] target;
    logic [31:0] p;
    logic [31:0] np;
    logic [17:0] h;
    logic [17:0] n;
    if (addr == 0) return;
    target = addr - shadow_base - 8;
    p = 0;
    while (64'(p) + 8 <= 64'(shadow_brk)) begin
      h = get_hdr(p);
      if (p == target) begin
        set_hdr(p, 32'(h[16:0]), 1'b0);
        break;
      end
      p = p + 8 + 32'(h[16:0]);
    end
    // forward merge pass
    p = 0;
    while (64'(p) + 8 <= 64'(shadow_brk)) begin
      h  = get_hdr(p);
      np = p + 8 + 32'(h[16:0]);
      if (!h[17] && 64'(np) + 8 <= 64'(shadow_brk)) begin
        n = get_hdr(np);
        if (!n[17]) begin
          set_hdr(p, 32'(h[16:0]) + 8 + 32'(n[16:0]), 1'b0);
          continue;
        end
      end
      p = np;
    end
  endfunction

  function automatic heap_res_t predict_word(heap_op_t op);
    heap_res_t r;
    if (op.func == FN_ALLOC) begin
      r = predict_alloc(op.request_size);
      if (!r.failed) live_addrs.push_back(r.result_addr);
    end else begin
      predict_release(op.block_addr);
      r = '0;
    end
    return r;
  endfunction

  // Driver: offers words from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req.valid        <= 1'b1;
        req.func         <= op_queue[0].func;
        req.request_size <= op_queue[0].request_size;
        req.block_addr   <= op_queue[0].block_addr;
        void'(op_queue.pop_front());
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Accepted words feed the predictor
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      expected_results.push_back(predict_word({req.func, req.request_size, req.block_addr}));
      words_sent++;
    end
  end

  // Receiver stall, with a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready   <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each result word with the oldest expectation
  always @(posedge clk) begin
    heap_res_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: addr %h failed %b",
               rsp.result_addr, rsp.failed);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (rsp.result_addr !== want.result_addr) begin
          $error("result_addr: expected %h, actual %h", want.result_addr, rsp.result_addr);
          err_count++;
        end
        if (rsp.failed !== want.failed) begin
          $error("failed: expected %b, actual %b", want.failed, rsp.failed);
          err_count++;
        end
        if (want.failed) alloc_fails++;
      end
      words_checked++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_alloc(logic [31:0] sz);
    op_queue.push_back({FN_ALLOC, sz, 32'($urandom)});
  endtask

  task automatic push_release(logic [31:0] addr);
    op_queue.push_back({FN_RELEASE, 32'($urandom), addr});
  endtask

  // Wait for every queued word to pass and the block to go quiet
  task automatic drain();
    while (op_queue.size() > 0 || req.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // One write, with the enable dropped again before the next can start
  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_BASE) shadow_base = val;
    else                      shadow_limit = val[16:0];
    @(posedge clk);
  endtask

  // Mostly small sizes; a few large ones and odd values
  function automatic logic [31:0] pick_size();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 80) return $urandom_range(1, 64);
    if (k < 92) return $urandom_range(65, 600);
    if (k < 96) return $urandom_range(601, 8000);
    return $urandom;
  endfunction

  // Release a live block, or a stray address now and then
  function automatic logic [31:0] pick_release();
    int unsigned k;
    int unsigned i;
    logic [31:0] a;
    k = $urandom_range(99);
    if (k < 85 && live_addrs.size() > 0) begin
      i = $urandom_range(live_addrs.size() - 1);
      a = live_addrs[i];
      live_addrs.delete(i);
      return a;
    end
    if (k < 92) return 32'd0;
    return $urandom;
  endfunction

  task automatic random_phase(int unsigned count, int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (count) begin
      if ($urandom_range(99) < 55) push_alloc(pick_size());
      else                         push_release(pick_release());
    end
    drain();
  endtask

  initial begin
    err_count = 0; cycle_count = 0; words_sent = 0; words_checked = 0;
    alloc_fails = 0; hold_cycles = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    shadow_base = '0; shadow_limit = LIMIT_RST; shadow_brk = '0;
    foreach (shadow_hdr[i]) shadow_hdr[i] = '0;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = REG_HEAP_BASE; cfg_wdata = '0;
    req.valid = 1'b0; req.func = FN_ALLOC; req.request_size = '0; req.block_addr = '0;
    rsp.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero size, overflow, edge sizes, splits, merges, odd releases
    push_alloc(32'd0);
    push_alloc(32'hFFFF_FFFD);
    push_alloc(32'hFFFF_FFFF);
    push_alloc(32'hFFFF_FFFC);
    push_alloc(32'd1);
    push_alloc(32'd40);
    push_alloc(32'd3);
    push_alloc(32'd4);
    push_release(32'd0);
    push_release(32'd20);            // 40-byte block
    push_alloc(32'd20);              // split, remainder 12
    push_alloc(32'd8);               // takes remainder
    push_release(32'd20);
    push_release(32'd20);            // already free
    push_release(32'd17);            // not a payload address
    push_release(32'hFFFF_FFFF);
    push_alloc(32'd65000);           // fits below the limit, fills most of the heap
    push_alloc(32'd65400);
    drain();

    // Base at the top, limit lowered below the break
    write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);
    write_reg(REG_HEAP_LIMIT, 32'd16);
    push_alloc(32'd4);
    push_alloc(32'd64);
    push_release(live_addrs.size() > 0 ? live_addrs[0] : 32'd0);
    drain();
    write_reg(REG_HEAP_LIMIT, 32'd0);
    push_alloc(32'd2);
    drain();

    // Random phases with varying settings and idling
    write_reg(REG_HEAP_BASE, $urandom);
    live_addrs.delete();
    write_reg(REG_HEAP_LIMIT, 32'd65536);
    random_phase(450, 24, 88);
    write_reg(REG_HEAP_LIMIT, 32'h1_FFFF);
    random_phase(450, 88, 24);
    write_reg(REG_HEAP_BASE, 32'd0);
    write_reg(REG_HEAP_LIMIT, 32'd2048);
    hold_cycles = 3000;
    random_phase(450, 0, 0);
    write_reg(REG_HEAP_BASE, $urandom);
    write_reg(REG_HEAP_LIMIT, $urandom_range(0, 65536));
    random_phase(450, 0, 0);

    $display("covered %0d words sent, %0d checked (%0d allocate failures) over several base and limit settings",
             words_sent, words_checked, alloc_fails);
    $display("idling patterns: sender heavy, receiver heavy, none, plus one long output stall");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> first_fit_heap_allocator.f
sv/ffha_pkg.sv
sv/ffha_if.sv
sv/ffha_ctrl.sv
sv/ffha_dpath.sv
sv/first_fit_heap_allocator.sv
sim/tb_first_fit_heap_allocator.sv
